// ----- rtl/cpg_pkg.sv -----
package cpg_pkg;

  localparam int CenterW = 12;
  localparam int RadiusW = 11;
  localparam int PixelW  = 14;
  localparam int DecW    = 15;

  // decision constants of the midpoint rule
  localparam logic [DecW-1:0] DecInit = DecW'(3);
  localparam logic [DecW-1:0] DecIncA = DecW'(6);
  localparam logic [DecW-1:0] DecIncB = DecW'(10);

  typedef enum logic {
    ReqStart = 1'b0,
    ReqStep  = 1'b1
  } req_e;

  typedef struct packed {
    req_e               req;
    logic [CenterW-1:0] center_x;
    logic [CenterW-1:0] center_y;
    logic [RadiusW-1:0] radius;
  } cmd_t;

endpackage

// ----- rtl/cpg_in_if.sv -----
interface cpg_in_if import cpg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [CenterW-1:0] center_x;
  logic [CenterW-1:0] center_y;
  logic [RadiusW-1:0] radius;

  modport source (output valid, output req_type, output center_x, output center_y,
                  output radius, input ready);
  modport sink   (input valid, input req_type, input center_x, input center_y,
                  input radius, output ready);
endinterface

// ----- rtl/cpg_out_if.sv -----
interface cpg_out_if import cpg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [PixelW-1:0] pixel_x;
  logic signed [PixelW-1:0] pixel_y;
  logic                     last_pixel;

  modport source (output valid, output pixel_x, output pixel_y, output last_pixel,
                  input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input last_pixel,
                  output ready);
endinterface

// ----- rtl/circle_pixel_generator.sv -----
// Midpoint circle rasterizer. A start beat (req_type 0) loads centre and radius and
// returns nothing; each step beat (req_type 1) returns one pixel, walking the eight
// reflections of the current offset before advancing it, with last_pixel set on the
// final one. Steps with no circle in progress return nothing. The block takes one
// beat per cycle sustained while out_o.ready holds, a rate set by the offset and
// decision update, which the back end computes combinationally. A step beat's pixel
// passes the input register, then the two-entry command queue, then the output
// register. Centre coordinates are masked to COORD_BITS; pixels wrap to 14 bits.
module circle_pixel_generator import cpg_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cpg_in_if.sink    in_i,
  cpg_out_if.source out_o
);

  logic f_valid, f_ready, q_valid, q_ready;
  cmd_t f_cmd, q_cmd;

  cpg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  cpg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_cmd)
  );

  cpg_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .out_o       (out_o)
  );

endmodule

// ----- rtl/cpg_front.sv -----
module cpg_front import cpg_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  cpg_in_if.sink in_i,
  output logic   cmd_valid_o,
  input  logic   cmd_ready_i,
  output cmd_t   cmd_o
);

  logic vld_q, vld_d;
  cmd_t cmd_q;
  logic take;

  // input register, refilled in the same cycle it drains
  assign in_i.ready = !vld_q || cmd_ready_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (cmd_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q.req      <= req_e'(in_i.req_type);
      cmd_q.center_x <= in_i.center_x;
      cmd_q.center_y <= in_i.center_y;
      cmd_q.radius   <= in_i.radius;
    end
  end

  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

endmodule

// ----- rtl/cpg_queue.sv -----
module cpg_queue import cpg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/cpg_back.sv -----
module cpg_back import cpg_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  output logic       cmd_ready_o,
  input  cmd_t       cmd_i,
  cpg_out_if.source  out_o
);

  localparam int CentreBits = (COORD_BITS < CenterW) ? COORD_BITS : CenterW;

  logic [CentreBits-1:0] col_q, row_q;
  logic [RadiusW-1:0]    x_q, y_q;
  logic [DecW-1:0]       dec_q;
  logic [2:0]            oct_q;
  logic                  active_q;

  logic                     out_vld_q;
  logic signed [PixelW-1:0] px_q, py_q;
  logic                     last_q;

  logic                  fire, is_start, emit;
  logic                  swap, neg_x, neg_y;
  logic [PixelW-1:0]     cx, cy, ax, ay, px, py;
  logic [DecW-1:0]       x_w, y_w, dec_nx;
  logic [RadiusW+1:0]    x_nx, y_nx;
  logic                  done;

  assign cmd_ready_o = !out_vld_q || out_o.ready;
  assign fire        = cmd_valid_i && cmd_ready_o;
  assign is_start    = (cmd_i.req == ReqStart);
  assign emit        = fire && !is_start && active_q;

  // second half of the octants swaps the offsets
  assign swap  = oct_q[2];
  assign neg_x = swap ? oct_q[1] : oct_q[0];
  assign neg_y = swap ? oct_q[0] : oct_q[1];

  assign cx = {{(PixelW-CentreBits){1'b0}}, col_q};
  assign cy = {{(PixelW-CentreBits){1'b0}}, row_q};
  assign ax = {{(PixelW-RadiusW){1'b0}}, (swap ? y_q : x_q)};
  assign ay = {{(PixelW-RadiusW){1'b0}}, (swap ? x_q : y_q)};
  assign px = neg_x ? (cx - ax) : (cx + ax);
  assign py = neg_y ? (cy - ay) : (cy + ay);

  // midpoint step, uses x before its increment
  assign x_w    = {{(DecW-RadiusW){1'b0}}, x_q};
  assign y_w    = {{(DecW-RadiusW){1'b0}}, y_q};
  assign dec_nx = dec_q[DecW-1] ? (dec_q + (x_w << 2) + DecIncA)
                                : (dec_q + ((x_w - y_w) << 2) + DecIncB);
  assign x_nx   = {2'b00, x_q} + (RadiusW+2)'(1);
  assign y_nx   = {2'b00, y_q} - (RadiusW+2)'(!dec_q[DecW-1]);
  assign done   = $signed(x_nx) > $signed(y_nx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      x_q       <= '0;
      y_q       <= '0;
      dec_q     <= '0;
      oct_q     <= '0;
      active_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (fire && is_start) begin
        col_q    <= cmd_i.center_x[CentreBits-1:0];
        row_q    <= cmd_i.center_y[CentreBits-1:0];
        x_q      <= '0;
        y_q      <= cmd_i.radius;
        dec_q    <= DecInit - {{(DecW-RadiusW-1){1'b0}}, cmd_i.radius, 1'b0};
        oct_q    <= '0;
        active_q <= 1'b1;
      end else if (emit) begin
        oct_q <= oct_q + 3'd1;
        if (oct_q == 3'd7) begin
          dec_q <= dec_nx;
          x_q   <= x_nx[RadiusW-1:0];
          y_q   <= y_nx[RadiusW-1:0];
          if (done) begin
            active_q <= 1'b0;
          end
        end
      end
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      px_q   <= px;
      py_q   <= py;
      last_q <= (oct_q == 3'd7) && done;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.pixel_x    = px_q;
  assign out_o.pixel_y    = py_q;
  assign out_o.last_pixel = last_q;

endmodule

// ----- tb/sv/testbench.sv -----
module testbench import cpg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 5000;
  localparam int HoldStart  = 1500;
  localparam int HoldLen    = 400;
  localparam int RandItems  = 2000;

  typedef struct {
    logic signed [PixelW-1:0] x;
    logic signed [PixelW-1:0] y;
    logic                     last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cpg_in_if  in_bus ();
  cpg_out_if out_bus ();

  circle_pixel_generator #(.COORD_BITS(CenterW)) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #10 clk = ~clk;

  cmd_t   cmd_backlog[$];
  pixel_t pending_pixels[$];
  cmd_t   cur_cmd;

  // rasterizer shadow state
  logic [CenterW-1:0]      ctr_col;
  logic [CenterW-1:0]      ctr_row;
  logic [RadiusW-1:0]      off_x;
  logic [RadiusW-1:0]      off_y;
  logic signed [DecW-1:0]  dec_val;
  logic [2:0]              oct;
  bit                      drawing;

  int     total_cmds;
  int     cmds_taken;
  int     pixels_seen;
  int     circles_done;
  int     err_count;
  int     stall_cnt;
  int     rx_cycle;
  int     hold_left;
  bit     hold_done;
  logic [1:0] idle_phase;
  int     send_idle_pct;
  int     recv_idle_pct;

  initial begin
    in_bus.valid    = 1'b0;
    in_bus.req_type = 1'b0;
    in_bus.center_x = '0;
    in_bus.center_y = '0;
    in_bus.radius   = '0;
    out_bus.ready   = 1'b0;
    ctr_col = '0;
    ctr_row = '0;
    off_x   = '0;
    off_y   = '0;
    dec_val = '0;
    oct     = '0;
    drawing = 1'b0;
    idle_phase = 2'd0;
  end

  function automatic int circle_steps(int r);
    int x, y, d, n;
    x = 0;
    y = r;
    d = 3 - 2 * r;
    n = 0;
    while (x <= y) begin
      n += 8;
      if (d < 0) begin
        d += 4 * x + 6;
      end else begin
        d += 4 * (x - y) + 10;
        y--;
      end
      x++;
    end
    return n;
  endfunction

  // advance the shadow rasterizer by one accepted beat
  task automatic trace_circle(cmd_t c);
    int cx, cy, x, y, px, py, d;
    pixel_t p;
    if (c.req == ReqStart) begin
      ctr_col = c.center_x;
      ctr_row = c.center_y;
      off_x   = '0;
      off_y   = c.radius;
      dec_val = DecW'(3 - 2 * int'(c.radius));
      oct     = '0;
      drawing = 1'b1;
      return;
    end
    if (!drawing) return;
    cx = int'(ctr_col);
    cy = int'(ctr_row);
    x  = int'(off_x);
    y  = int'(off_y);
    case (oct)
      3'd0: begin px = cx + x; py = cy + y; end
      3'd1: begin px = cx - x; py = cy + y; end
      3'd2: begin px = cx + x; py = cy - y; end
      3'd3: begin px = cx - x; py = cy - y; end
      3'd4: begin px = cx + y; py = cy + x; end
      3'd5: begin px = cx + y; py = cy - x; end
      3'd6: begin px = cx - y; py = cy + x; end
      default: begin px = cx - y; py = cy - x; end
    endcase
    p.x = px[PixelW-1:0];
    p.y = py[PixelW-1:0];
    p.last = 1'b0;
    if (oct == 3'd7) begin
      d = dec_val;
      if (d < 0) begin
        d = d + 4 * x + 6;
      end else begin
        d = d + 4 * (x - y) + 10;
        y = y - 1;
      end
      x = x + 1;
      dec_val = d[DecW-1:0];
      if (x > y) begin
        drawing = 1'b0;
        p.last  = 1'b1;
      end
      off_x = x[RadiusW-1:0];
      off_y = y[RadiusW-1:0];
      oct   = '0;
    end else begin
      oct = oct + 3'd1;
    end
    pending_pixels.push_back(p);
  endtask

  task automatic add_cmd(req_e r, int cx, int cy, int rad);
    cmd_t c;
    c.req      = r;
    c.center_x = cx[CenterW-1:0];
    c.center_y = cy[CenterW-1:0];
    c.radius   = rad[RadiusW-1:0];
    cmd_backlog.push_back(c);
  endtask

  // steps carry random centre and radius bits, which the block ignores
  task automatic add_steps(int n);
    for (int i = 0; i < n; i++)
      add_cmd(ReqStep, $urandom_range(0, 4095), $urandom_range(0, 4095),
              $urandom_range(0, 2047));
  endtask

  task automatic report_mismatch(string what, int got, int want);
    if (err_count < 50)
      $display("mismatch %s: got %0d, want %0d (pixel %0d)", what, got, want, pixels_seen);
    err_count++;
  endtask

  // driver: presents backlog beats and predicts on every accepted one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        trace_circle(cur_cmd);
        cmds_taken++;
        if (cmds_taken * 3 >= total_cmds * 2) idle_phase <= 2'd2;
        else if (cmds_taken * 3 >= total_cmds) idle_phase <= 2'd1;
      end
      if (in_bus.valid && !in_bus.ready) begin
        // hold the beat until taken
      end else if (cmd_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_cmd = cmd_backlog.pop_front();
        in_bus.valid    <= 1'b1;
        in_bus.req_type <= cur_cmd.req;
        in_bus.center_x <= cur_cmd.center_x;
        in_bus.center_y <= cur_cmd.center_y;
        in_bus.radius   <= cur_cmd.radius;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  always_comb begin
    case (idle_phase)
      2'd0:    begin send_idle_pct = 19; recv_idle_pct = 72; end
      2'd1:    begin send_idle_pct = 72; recv_idle_pct = 19; end
      default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
    endcase
  end

  // receiver ready, with one long hold-off to fill the block
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      rx_cycle  = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      rx_cycle++;
      if (!hold_done && rx_cycle == HoldStart) begin
        hold_left = HoldLen;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected pixel x", out_bus.pixel_x, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_bus.pixel_x !== want.x) report_mismatch("pixel_x", out_bus.pixel_x, want.x);
        if (out_bus.pixel_y !== want.y) report_mismatch("pixel_y", out_bus.pixel_y, want.y);
        if (out_bus.last_pixel !== want.last)
          report_mismatch("last_pixel", out_bus.last_pixel, want.last);
        if (want.last) circles_done++;
      end
      pixels_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        stall_cnt = 0;
      end else begin
        stall_cnt++;
        if (stall_cnt >= StallLimit) begin
          $display("timeout: no beat for %0d cycles", StallLimit);
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    int added, kind, r, n;
    cmds_taken   = 0;
    pixels_seen  = 0;
    circles_done = 0;
    err_count    = 0;
    stall_cnt    = 0;

    // directed: step with no circle, zero radius, field extremes, restart mid-circle
    add_steps(1);
    add_cmd(ReqStart, 0, 0, 0);
    add_steps(9);
    add_cmd(ReqStart, 4095, 4095, 2047);
    add_steps(3);
    add_cmd(ReqStart, 0, 0, 2047);
    add_steps(9);

    added = 0;
    while (added < RandItems) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        r = $urandom_range(0, 40);
        n = circle_steps(r);
      end else if (kind < 85) begin
        r = $urandom_range(0, 2047);
        n = $urandom_range(0, 40);
      end else if (kind < 95) begin
        r = $urandom_range(0, 6);
        n = circle_steps(r) + $urandom_range(1, 4);
      end else begin
        r = -1;
        n = $urandom_range(1, 5);
      end
      if (r >= 0) begin
        add_cmd(ReqStart, $urandom_range(0, 4095), $urandom_range(0, 4095), r);
        add_steps(n);
        added += n + 1;
      end else begin
        for (int i = 0; i < n; i++)
          add_cmd($urandom_range(0, 1) ? ReqStep : ReqStart, $urandom_range(0, 4095),
                  $urandom_range(0, 4095), $urandom_range(0, 2047));
        added += n;
      end
    end
    total_cmds = cmd_backlog.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (cmd_backlog.size() != 0 || in_bus.valid) @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d beats sent, %0d pixels checked, %0d circles drawn to the end",
             cmds_taken, pixels_seen, circles_done);
    $display("%0d mismatches", err_count);
    if (err_count == 0 && pending_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
